@@ src/mdsc_pkg.sv @@
// shared types, constants and the size classifier function for the size classifier
package mdsc_pkg;

	localparam int LEVEL_W = 12;
	localparam int RUN_W   = 16;
	localparam int TALLY_W = 4;
	localparam int SIZE_W  = 2;
	localparam int SUM_W   = TALLY_W + 2;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	localparam logic [SIZE_W-1:0] SIZE_NONE   = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_SMALL  = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_MEDIUM = 2'd2;
	localparam logic [SIZE_W-1:0] SIZE_LARGE  = 2'd3;

	localparam logic [IDX_W-1:0] REG_ENTRY   = 3'd0;
	localparam logic [IDX_W-1:0] REG_RELEASE = 3'd1;
	localparam logic [IDX_W-1:0] REG_LARGE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MEDIUM  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SMALL   = 3'd4;

	typedef struct packed {
		logic [LEVEL_W-1:0] entry_thr;
		logic [RUN_W-1:0]   release_cnt;
		logic [LEVEL_W-1:0] large_thr;
		logic [LEVEL_W-1:0] medium_thr;
		logic [LEVEL_W-1:0] small_thr;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		entry_thr:   12'd3000,
		release_cnt: 16'd10,
		large_thr:   12'd1000,
		medium_thr:  12'd2000,
		small_thr:   12'd3000
	};

	function automatic logic [SIZE_W-1:0] classify(input logic [LEVEL_W-1:0] level,
		input cfg_t cfg);
		logic [SIZE_W-1:0] size;
		if (level < cfg.large_thr) begin
			size = SIZE_LARGE;
		end else if (level < cfg.medium_thr) begin
			size = SIZE_MEDIUM;
		end else if (level < cfg.small_thr) begin
			size = SIZE_SMALL;
		end else begin
			size = SIZE_NONE;
		end
		return size;
	endfunction

endpackage

@@ src/metal_detect_size_classifier_unit.sv @@
// top level of the metal detector size classifier
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  sample_level
// out      out  out_valid / out_stall live_size, small/medium/large/total_tally
// cfg      in   apb-style            entry, release count, size thresholds
//
// one word per clock while out_stall is low; a word lands in the input register,
// then the phase sequencer updates state and the result register from it
// the result register is the state, so a stalled result holds the next word in
// the input register; stall on the input rises only when both are full
// reset clears phase, tallies, run counter and registers to their defaults
module metal_detect_size_classifier_unit import mdsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [LEVEL_W-1:0] sample_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SIZE_W-1:0]  live_size,
	output logic [TALLY_W-1:0] small_tally,
	output logic [TALLY_W-1:0] medium_tally,
	output logic [TALLY_W-1:0] large_tally,
	output logic [TALLY_W-1:0] total_tally
);

	cfg_t cfg;

	mdsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mdsc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_level (sample_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.live_size    (live_size),
		.small_tally  (small_tally),
		.medium_tally (medium_tally),
		.large_tally  (large_tally),
		.total_tally  (total_tally)
	);

endmodule

@@ src/mdsc_regs.sv @@
// configuration register bank behind the apb-style port
module mdsc_regs import mdsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_ENTRY:   cfg_q.entry_thr   <= pwdata[LEVEL_W-1:0];
				REG_RELEASE: cfg_q.release_cnt <= pwdata[RUN_W-1:0];
				REG_LARGE:   cfg_q.large_thr   <= pwdata[LEVEL_W-1:0];
				REG_MEDIUM:  cfg_q.medium_thr  <= pwdata[LEVEL_W-1:0];
				REG_SMALL:   cfg_q.small_thr   <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENTRY:   prdata = DATA_W'(cfg_q.entry_thr);
			REG_RELEASE: prdata = DATA_W'(cfg_q.release_cnt);
			REG_LARGE:   prdata = DATA_W'(cfg_q.large_thr);
			REG_MEDIUM:  prdata = DATA_W'(cfg_q.medium_thr);
			REG_SMALL:   prdata = DATA_W'(cfg_q.small_thr);
			default:     prdata = '0;
		endcase
	end

endmodule

@@ src/mdsc_core.sv @@
// input register, phase sequencer, tallies and result register
module mdsc_core import mdsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [LEVEL_W-1:0] sample_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SIZE_W-1:0]  live_size,
	output logic [TALLY_W-1:0] small_tally,
	output logic [TALLY_W-1:0] medium_tally,
	output logic [TALLY_W-1:0] large_tally,
	output logic [TALLY_W-1:0] total_tally
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DETECT,
		PH_HOLD,
		PH_RELEASE
	} phase_t;

	phase_t             phase_q, phase_nxt;
	logic [LEVEL_W-1:0] lowest_q, lowest_nxt;
	logic [RUN_W-1:0]   run_q, run_nxt, run_inc;
	logic [SIZE_W-1:0]  shown_q, shown_nxt, hold_size;
	logic [TALLY_W-1:0] sml_q, sml_nxt, med_q, med_nxt, lrg_q, lrg_nxt;
	logic [TALLY_W-1:0] total_q, total_nxt;
	logic [SUM_W-1:0]   sum_cur, sum_nxt;
	logic               valid_s1, out_valid_q;
	logic [LEVEL_W-1:0] level_s1;
	logic               adv, above, run_hit;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	assign above     = level_s1 > cfg.entry_thr;
	assign run_inc   = run_q + 1'b1;
	assign run_hit   = run_inc >= cfg.release_cnt;
	assign hold_size = classify(lowest_q, cfg);
	assign sum_cur   = SUM_W'(sml_q) + SUM_W'(med_q) + SUM_W'(lrg_q);

	always_comb begin
		phase_nxt  = phase_q;
		lowest_nxt = lowest_q;
		run_nxt    = run_q;
		shown_nxt  = shown_q;
		sml_nxt    = sml_q;
		med_nxt    = med_q;
		lrg_nxt    = lrg_q;
		case (phase_q)
			PH_IDLE: begin
				shown_nxt = SIZE_NONE;
				if (level_s1 < cfg.entry_thr) begin
					lowest_nxt = LEVEL_MAX;
					run_nxt    = '0;
					phase_nxt  = PH_DETECT;
				end
			end
			PH_DETECT: begin
				if (level_s1 < lowest_q) begin
					lowest_nxt = level_s1;
					shown_nxt  = classify(level_s1, cfg);
				end
				if (!above) begin
					run_nxt = '0;
				end else if (run_hit) begin
					run_nxt   = '0;
					phase_nxt = PH_HOLD;
				end else begin
					run_nxt = run_inc;
				end
			end
			PH_HOLD: begin
				if (sum_cur < SUM_W'(TALLY_MAX)) begin
					if (hold_size == SIZE_SMALL && sml_q < TALLY_MAX) begin
						sml_nxt = sml_q + 1'b1;
					end else if (hold_size == SIZE_MEDIUM && med_q < TALLY_MAX) begin
						med_nxt = med_q + 1'b1;
					end else if (hold_size == SIZE_LARGE && lrg_q < TALLY_MAX) begin
						lrg_nxt = lrg_q + 1'b1;
					end
				end
				run_nxt   = '0;
				phase_nxt = PH_RELEASE;
			end
			default: begin
				if (!above) begin
					run_nxt = '0;
				end else if (run_hit) begin
					run_nxt   = '0;
					phase_nxt = PH_IDLE;
				end else begin
					run_nxt = run_inc;
				end
			end
		endcase
		sum_nxt = SUM_W'(sml_nxt) + SUM_W'(med_nxt) + SUM_W'(lrg_nxt);
		if (sum_nxt > SUM_W'(TALLY_MAX)) begin
			total_nxt = TALLY_MAX;
		end else begin
			total_nxt = sum_nxt[TALLY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			level_s1    <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			lowest_q    <= LEVEL_MAX;
			run_q       <= '0;
			shown_q     <= SIZE_NONE;
			sml_q       <= '0;
			med_q       <= '0;
			lrg_q       <= '0;
			total_q     <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
				level_s1 <= sample_level;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_nxt;
				lowest_q    <= lowest_nxt;
				run_q       <= run_nxt;
				shown_q     <= shown_nxt;
				sml_q       <= sml_nxt;
				med_q       <= med_nxt;
				lrg_q       <= lrg_nxt;
				total_q     <= total_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign live_size    = shown_q;
	assign small_tally  = sml_q;
	assign medium_tally = med_q;
	assign large_tally  = lrg_q;
	assign total_tally  = total_q;

endmodule

@@ src/mdsc_checker.sv @@
// port-level checks for the size classifier and their bind
module mdsc_checker import mdsc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [SIZE_W-1:0]  live_size,
	input logic [TALLY_W-1:0] small_tally,
	input logic [TALLY_W-1:0] medium_tally,
	input logic [TALLY_W-1:0] large_tally,
	input logic [TALLY_W-1:0] total_tally
);

	logic [SUM_W-1:0] sum;

	assign sum = SUM_W'(small_tally) + SUM_W'(medium_tally) + SUM_W'(large_tally);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(live_size)
			&& $stable(total_tally) && $stable(small_tally))
		else $error("stalled result word changed");

	a_total_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> SUM_W'(total_tally) == sum)
		else $error("total does not match tallies");

	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		total_tally >= $past(total_tally))
		else $error("total went down");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled input word withdrawn");

endmodule

bind metal_detect_size_classifier_unit mdsc_checker u_mdsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.live_size    (live_size),
	.small_tally  (small_tally),
	.medium_tally (medium_tally),
	.large_tally  (large_tally),
	.total_tally  (total_tally)
);
